// File: hdl/trle_pkg.sv
// ============================================================================
// trle_pkg: shared types and constants for the tile RLE stream decoder
// Field widths, register indexes, decoder phase codes and the state and
// status records that pass between the decoder modules.
// ============================================================================
package trle_pkg;

    // Fixed field widths
    localparam int DATA_W    = 8;
    localparam int START_W   = 18;
    localparam int LEN_W     = 7;
    localparam int SKIP_W    = 3;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP    = 2'd1;

    // Parameter defaults and register reset values
    localparam int MAX_TILES_DEF   = 256;
    localparam int TILE_BYTES_DEF  = 1024;
    localparam int CAP_TILES_RST   = 240;
    localparam int GROUP_TILES_RST = 60;

    // Skip lengths after an end-of-tile pixel
    localparam logic [SKIP_W-1:0] SKIP_SHORT = 3'd2;
    localparam logic [SKIP_W-1:0] SKIP_LONG  = 3'd4;

    // Decoder phases
    typedef enum logic [4:0] {
        PH_HEADER   = 5'b00001,
        PH_VALUE    = 5'b00010,
        PH_LITERAL  = 5'b00100,
        PH_TILE_END = 5'b01000,
        PH_SKIP     = 5'b10000
    } phase_t;

    // Decoder state apart from the position
    typedef struct packed {
        phase_t              phase;
        logic [LEN_W-1:0]    lit;
        logic [SKIP_W-1:0]   skip;
        logic                full;
    } dec_state_t;

    // One run record as produced by the decode step
    typedef struct packed {
        logic                emit;
        logic [DATA_W-1:0]   value;
        logic [LEN_W-1:0]    len;
        logic                tend;
    } run_t;

    // Status of the tile group tracker
    typedef struct packed {
        logic busy;
        logic hit;
    } grp_status_t;

endpackage

// File: hdl/trle_step.sv
// ============================================================================
// trle_step: decode step for one stream byte
// Combinational next-state logic: header parsing, run emission with
// clipping at capacity, and the skip sequence after an end-of-tile pixel.
// ============================================================================
module trle_step #(
    parameter int POS_W = 19
) (
    input  trle_pkg::dec_state_t              st,
    input  logic [trle_pkg::DATA_W-1:0]       data_byte,
    input  logic [POS_W-1:0]                  pos,
    input  logic [POS_W-1:0]                  cap,
    input  logic                              group_hit,
    output trle_pkg::dec_state_t              st_next,
    output logic [POS_W-1:0]                  pos_next,
    output trle_pkg::run_t                    run
);
    import trle_pkg::*;

    dec_state_t        st_dec;
    logic              emit;
    logic [LEN_W-1:0]  req_len;
    logic              tend;
    logic [POS_W-1:0]  room;
    logic [LEN_W-1:0]  len_clip;
    logic [SKIP_W-1:0] skip_dec;

    // Phase decode: choose the next phase and what run this byte makes.
    always_comb
    begin
        st_dec   = st;
        emit     = 1'b0;
        req_len  = LEN_W'(1);
        tend     = 1'b0;
        skip_dec = (st.skip != '0) ? st.skip - SKIP_W'(1) : '0;
        if (!st.full)
        begin
            case (st.phase)
                PH_HEADER:
                begin
                    st_dec.lit = data_byte[LEN_W-1:0];
                    if (data_byte[DATA_W-1])
                    begin
                        st_dec.phase = PH_VALUE;
                    end
                    else if (data_byte != '0)
                    begin
                        st_dec.phase = PH_LITERAL;
                    end
                    else
                    begin
                        st_dec.lit   = st.lit;
                        st_dec.phase = PH_TILE_END;
                    end
                end
                PH_VALUE:
                begin
                    emit         = (st.lit != '0);
                    req_len      = st.lit;
                    st_dec.lit   = '0;
                    st_dec.phase = PH_HEADER;
                end
                PH_LITERAL:
                begin
                    emit       = 1'b1;
                    st_dec.lit = st.lit - LEN_W'(1);
                    if (st.lit == LEN_W'(1))
                    begin
                        st_dec.phase = PH_HEADER;
                    end
                end
                PH_TILE_END:
                begin
                    emit         = 1'b1;
                    tend         = 1'b1;
                    st_dec.skip  = group_hit ? SKIP_LONG : SKIP_SHORT;
                    st_dec.phase = PH_SKIP;
                end
                PH_SKIP:
                begin
                    st_dec.skip = skip_dec;
                    if (skip_dec == '0)
                    begin
                        st_dec.phase = PH_HEADER;
                    end
                end
                default:
                begin
                    st_dec.phase = PH_HEADER;
                end
            endcase
        end
    end

    // Clip the run to the room left and advance the position.
    always_comb
    begin
        room     = (pos < cap) ? cap - pos : '0;
        len_clip = (POS_W'(req_len) > room) ? LEN_W'(room) : req_len;
        pos_next = emit ? pos + POS_W'(len_clip) : pos;
        st_next  = st_dec;
        if (emit && (pos_next >= cap))
        begin
            st_next.full = 1'b1;
        end
    end

    assign run.emit  = emit;
    assign run.value = data_byte;
    assign run.len   = len_clip;
    assign run.tend  = tend;

endmodule

// File: hdl/trle_group.sv
// ============================================================================
// trle_group: tile group tracker
// Keeps the tile index of the position modulo the group size, updated as
// the position moves, and rebuilt bit-serially after the group size changes.
// ============================================================================
module trle_group #(
    parameter int POS_W   = 19,
    parameter int TB_LOG2 = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          grp_load,
    input  logic [trle_pkg::CFG_W-1:0]    grp,
    input  logic                          advance,
    input  logic [POS_W-1:0]              pos,
    input  logic [POS_W-1:0]              pos_next,
    output trle_pkg::grp_status_t         status
);
    import trle_pkg::*;

    localparam int TIDX_W = POS_W - TB_LOG2;
    localparam int BIDX_W = (TIDX_W > 1) ? $clog2(TIDX_W) : 1;

    logic [CFG_W-1:0]  mod_reg;
    logic [CFG_W-1:0]  mod_next;
    logic              busy_reg;
    logic              busy_next;
    logic [BIDX_W-1:0] bit_reg;
    logic [BIDX_W-1:0] bit_next;

    logic [TIDX_W-1:0] tile_cur;
    logic [TIDX_W-1:0] tile_nx;
    logic [1:0]        tile_step;
    logic [CFG_W:0]    grp_ext;
    logic [CFG_W:0]    mod_a;
    logic [CFG_W:0]    mod_b;
    logic [CFG_W:0]    mod_c;
    logic [CFG_W:0]    rem_sh;
    logic [CFG_W:0]    rem_red;

    assign tile_cur  = pos[POS_W-1:TB_LOG2];
    assign tile_nx   = pos_next[POS_W-1:TB_LOG2];
    assign tile_step = 2'(tile_nx - tile_cur);
    assign grp_ext   = {1'b0, grp};

    // Incremental update: a run crosses at most two tile boundaries.
    always_comb
    begin
        mod_a = {1'b0, mod_reg} + (CFG_W+1)'(tile_step);
        mod_b = (mod_a >= grp_ext) ? mod_a - grp_ext : mod_a;
        mod_c = (mod_b >= grp_ext) ? mod_b - grp_ext : mod_b;
    end

    // Restoring remainder step, one tile index bit per cycle.
    always_comb
    begin
        rem_sh  = {mod_reg, tile_cur[bit_reg]};
        rem_red = (rem_sh >= grp_ext) ? rem_sh - grp_ext : rem_sh;
    end

    // Tracker control: rebuild after a group write, otherwise follow the position.
    always_comb
    begin
        mod_next  = mod_reg;
        busy_next = busy_reg;
        bit_next  = bit_reg;
        if (grp_load)
        begin
            mod_next  = '0;
            busy_next = 1'b1;
            bit_next  = BIDX_W'(TIDX_W - 1);
        end
        else if (busy_reg)
        begin
            mod_next = CFG_W'(rem_red);
            bit_next = bit_reg - BIDX_W'(1);
            if (bit_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
        else if (advance)
        begin
            mod_next = CFG_W'(mod_c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg  <= '0;
            busy_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            mod_reg  <= mod_next;
            busy_reg <= busy_next;
            bit_reg  <= bit_next;
        end
    end

    // The next byte lands on a group boundary when the low position bits are
    // all ones and the tile index is one short of a multiple of the group.
    assign status.busy = busy_reg;
    assign status.hit  = (&pos[TB_LOG2-1:0]) && (grp != '0)
                         && (mod_reg == grp - CFG_W'(1));

endmodule

// File: hdl/tile_rle_stream_decoder.sv
// ============================================================================
// tile_rle_stream_decoder: tile pixel run-length stream decoder
// Takes one compressed byte per transfer and produces at most one run record
// (start position, value, length, end-of-tile and full flags) per byte.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    data_byte
//   out      output     out_valid / out_stall  start_position, pixel_value,
//                                              run_length, tile_end, store_full
//   cfg      input      cfg_write              cfg_index, cfg_data
//
// One byte per cycle sustained while the output is not stalled and no group rebuild runs; a byte
// enters the input register, is decoded by one combinational pass and its run is then registered
// in the output register.
// A write to group_tiles rebuilds the tile-group remainder one bit per cycle;
// input is stalled while the rebuild runs.
// Reset is asynchronous and active low and clears all control state.
// A stalled output holds its record while the input register keeps taking a
// byte; the input stalls only when both registers are occupied or a rebuild runs.
// TILE_BYTES must be a power of two.
// ============================================================================
module tile_rle_stream_decoder #(
    parameter int MAX_TILES  = trle_pkg::MAX_TILES_DEF,
    parameter int TILE_BYTES = trle_pkg::TILE_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [trle_pkg::DATA_W-1:0]       data_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [trle_pkg::START_W-1:0]      start_position,
    output logic [trle_pkg::DATA_W-1:0]       pixel_value,
    output logic [trle_pkg::LEN_W-1:0]        run_length,
    output logic                              tile_end,
    output logic                              store_full,
    input  logic                              cfg_write,
    input  logic [trle_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trle_pkg::CFG_W-1:0]        cfg_data
);
    import trle_pkg::*;

    localparam int TB_LOG2 = $clog2(TILE_BYTES);
    localparam int POS_W   = $clog2(MAX_TILES * TILE_BYTES + 1);
    localparam int CT_W    = $clog2(MAX_TILES + 1);
    localparam int CapRstTiles = (CAP_TILES_RST > MAX_TILES) ? MAX_TILES : CAP_TILES_RST;
    localparam logic [POS_W-1:0] CapRst = POS_W'(CapRstTiles) << TB_LOG2;

    // Configuration registers
    logic [POS_W-1:0] cap_reg;
    logic [POS_W-1:0] cap_next;
    logic [CFG_W-1:0] grp_reg;
    logic [CT_W-1:0]  cap_tiles;
    logic             grp_load;

    // Input register
    logic              in_vld_reg;
    logic              in_vld_next;
    logic [DATA_W-1:0] in_byte_reg;

    // Decoder state
    dec_state_t       st_reg;
    dec_state_t       st_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    run_t             run;
    grp_status_t      grp_status;
    logic             advance;

    // Output register
    logic               out_vld_reg;
    logic               out_vld_next;
    logic [START_W-1:0] out_start_reg;
    logic [DATA_W-1:0]  out_value_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic               out_tend_reg;
    logic               out_full_reg;

    // Capacity write: clamp the tile count into range and convert to bytes.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cap_tiles = CT_W'(1);
        end
        else if (32'(cfg_data) > 32'(MAX_TILES))
        begin
            cap_tiles = CT_W'(MAX_TILES);
        end
        else
        begin
            cap_tiles = CT_W'(cfg_data);
        end
        cap_next = cap_reg;
        if (cfg_write && (cfg_index == REG_CAPACITY))
        begin
            cap_next = POS_W'(cap_tiles) << TB_LOG2;
        end
    end

    assign grp_load = cfg_write && (cfg_index == REG_GROUP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CapRst;
            grp_reg <= CFG_W'(GROUP_TILES_RST);
        end
        else
        begin
            cap_reg <= cap_next;
            if (grp_load)
            begin
                grp_reg <= cfg_data;
            end
        end
    end

    // Handshake: the input register moves on whenever the output can take a record and no group rebuild runs.
    assign advance     = in_vld_reg && !grp_status.busy && !(out_vld_reg && out_stall);
    assign in_stall    = grp_status.busy || (in_vld_reg && !advance);
    assign in_vld_next = (in_valid && !in_stall) ? 1'b1 : (advance ? 1'b0 : in_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= data_byte;
        end
    end

    // Decode step for the byte in the input register
    trle_step #(
        .POS_W (POS_W)
    ) u_step (
        .st        (st_reg),
        .data_byte (in_byte_reg),
        .pos       (pos_reg),
        .cap       (cap_reg),
        .group_hit (grp_status.hit),
        .st_next   (st_next),
        .pos_next  (pos_next),
        .run       (run)
    );

    // Tile group remainder tracker
    trle_group #(
        .POS_W   (POS_W),
        .TB_LOG2 (TB_LOG2)
    ) u_group (
        .clk      (clk),
        .rst_n    (rst_n),
        .grp_load (grp_load),
        .grp      (grp_reg),
        .advance  (advance),
        .pos      (pos_reg),
        .pos_next (pos_next),
        .status   (grp_status)
    );

    // Decoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase <= PH_HEADER;
            st_reg.lit   <= '0;
            st_reg.skip  <= '0;
            st_reg.full  <= 1'b0;
            pos_reg      <= '0;
        end
        else if (advance)
        begin
            st_reg  <= st_next;
            pos_reg <= pos_next;
        end
    end

    // Output register: load a run record, drop it once transferred.
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance && run.emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && run.emit)
        begin
            out_start_reg <= START_W'(pos_reg);
            out_value_reg <= run.value;
            out_len_reg   <= run.len;
            out_tend_reg  <= run.tend;
            out_full_reg  <= st_next.full;
        end
    end

    assign out_valid      = out_vld_reg;
    assign start_position = out_start_reg;
    assign pixel_value    = out_value_reg;
    assign run_length     = out_len_reg;
    assign tile_end       = out_tend_reg;
    assign store_full     = out_full_reg;

`ifndef SYNTHESIS
    // Once the store is full the position never moves again.
    a_full_freezes_pos: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.full |=> $stable(pos_reg))
        else $error("position changed after the store became full");

    // While the group remainder is rebuilt no byte may enter.
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        grp_status.busy |-> in_stall)
        else $error("input not stalled during group remainder rebuild");

    // A run of length zero can only come in a record that marks the store full.
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_full_reg) |-> (out_len_reg != '0))
        else $error("empty run record without full store");

    // An end-of-tile record carries a single pixel unless clipped at capacity.
    a_tend_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_tend_reg) |-> ((out_len_reg == LEN_W'(1)) || out_full_reg))
        else $error("end-of-tile record with a length other than one");
`endif

endmodule

// File: dv/tb_tile_rle_stream_decoder.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_tile_rle_stream_decoder: self-checking bench for the tile RLE decoder
// Streams compressed tile bytes through the decoder with random sender gaps
// and receiver stalls. A run tracker class decodes every accepted byte on its
// own and checks each run record leaving the block in order, field by field.
// The two registers go through several settings between phases, and the run
// ends by filling the store and feeding bytes that must be ignored.
// ============================================================================
module tb_tile_rle_stream_decoder;
    import trle_pkg::*;

    // Indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASE_ITEMS  = 190;
    localparam int PHASE_COUNT  = 5;

    // One run record as it should leave the block
    typedef struct packed {
        logic [START_W-1:0] start;
        logic [DATA_W-1:0]  value;
        logic [LEN_W-1:0]   len;
        logic               tend;
        logic               full;
    } run_rec_t;

    // Decodes accepted bytes and holds the runs still to come out
    class tile_run_predictor;
        int unsigned       cap_tiles;
        int unsigned       grp_tiles;
        phase_t            phase;
        logic [LEN_W-1:0]  lit;
        logic [SKIP_W-1:0] skip;
        int unsigned       pos;
        bit                full;
        run_rec_t          runs_due[$];
        int unsigned       errors;
        int unsigned       runs_checked;
        int unsigned       tile_ends;
        int unsigned       group_hits;
        int unsigned       bytes_taken;

        function new();
            cap_tiles    = CAP_TILES_RST;
            grp_tiles    = GROUP_TILES_RST;
            phase        = PH_HEADER;
            lit          = '0;
            skip         = '0;
            pos          = 0;
            full         = 1'b0;
            errors       = 0;
            runs_checked = 0;
            tile_ends    = 0;
            group_hits   = 0;
            bytes_taken  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_CAPACITY: cap_tiles = val;
                REG_GROUP:    grp_tiles = val;
                default:      ;
            endcase
        endfunction

        // Store size in bytes, with the tile count clamped to its legal range
        function int unsigned cap_bytes();
            int unsigned t;
            t = cap_tiles;
            if (t < 1) t = 1;
            if (t > MAX_TILES_DEF) t = MAX_TILES_DEF;
            return t * TILE_BYTES_DEF;
        endfunction

        // Clip a run to the room left, advance the position and queue it
        function void add_run(logic [DATA_W-1:0] value, int unsigned len, bit tend);
            int unsigned room;
            run_rec_t    r;
            room   = (pos < cap_bytes()) ? cap_bytes() - pos : 0;
            if (len > room) len = room;
            r.start = pos[START_W-1:0];
            r.value = value;
            r.len   = len[LEN_W-1:0];
            r.tend  = tend;
            pos += len;
            if (pos >= cap_bytes()) full = 1'b1;
            r.full = full;
            if (tend) tile_ends++;
            runs_due.push_back(r);
        endfunction

        // Note one accepted stream byte
        function void take_byte(logic [DATA_W-1:0] b);
            int unsigned gb;
            bytes_taken++;
            if (full) return;
            case (phase)
                PH_HEADER:
                begin
                    if (b[7])
                    begin
                        lit   = b[6:0];
                        phase = PH_VALUE;
                    end
                    else if (b != 0)
                    begin
                        lit   = b[6:0];
                        phase = PH_LITERAL;
                    end
                    else
                    begin
                        phase = PH_TILE_END;
                    end
                end
                PH_VALUE:
                begin
                    if (lit != 0) add_run(b, lit, 1'b0);
                    lit   = '0;
                    phase = PH_HEADER;
                end
                PH_LITERAL:
                begin
                    add_run(b, 1, 1'b0);
                    lit = lit - 1'b1;
                    if (lit == 0) phase = PH_HEADER;
                end
                PH_TILE_END:
                begin
                    gb = grp_tiles * TILE_BYTES_DEF;
                    add_run(b, 1, 1'b1);
                    skip = SKIP_SHORT;
                    if (gb != 0 && pos != 0 && (pos % gb) == 0)
                    begin
                        skip = SKIP_LONG;
                        group_hits++;
                    end
                    phase = PH_SKIP;
                end
                default:
                begin
                    if (skip > 0) skip = skip - 1'b1;
                    if (skip == 0) phase = PH_HEADER;
                end
            endcase
        endfunction

        // Compare one run leaving the block with the oldest one due
        function void check_run(run_rec_t got);
            run_rec_t want;
            if (runs_due.size() == 0)
            begin
                $error("unexpected run: start_position %0d pixel_value %0d run_length %0d",
                       got.start, got.value, got.len);
                errors++;
                return;
            end
            want = runs_due.pop_front();
            runs_checked++;
            if (got.start !== want.start)
            begin
                $error("start_position: expected %0d, actual %0d", want.start, got.start);
                errors++;
            end
            if (got.value !== want.value)
            begin
                $error("pixel_value: expected %0d, actual %0d", want.value, got.value);
                errors++;
            end
            if (got.len !== want.len)
            begin
                $error("run_length: expected %0d, actual %0d", want.len, got.len);
                errors++;
            end
            if (got.tend !== want.tend)
            begin
                $error("tile_end: expected %0d, actual %0d", want.tend, got.tend);
                errors++;
            end
            if (got.full !== want.full)
            begin
                $error("store_full: expected %0d, actual %0d", want.full, got.full);
                errors++;
            end
        endfunction
    endclass

    // Clock, reset and block inputs
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [DATA_W-1:0]  data_byte = '0;
    logic               out_stall = 1'b0;
    logic               cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    // Block outputs
    logic               in_stall;
    logic               out_valid;
    logic [START_W-1:0] start_position;
    logic [DATA_W-1:0]  pixel_value;
    logic [LEN_W-1:0]   run_length;
    logic               tile_end;
    logic               store_full;

    tile_run_predictor pred = new();

    int unsigned burst_left = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned settings_used = 0;

    always #6 clk = ~clk;

    tile_rle_stream_decoder uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .start_position (start_position),
        .pixel_value    (pixel_value),
        .run_length     (run_length),
        .tile_end       (tile_end),
        .store_full     (store_full),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Receiver stall pattern: modes of random length, including no stalls
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ((stall_left % 11) < 4);
        endcase
    end

    // Check every run transfer and watch for a hung handshake
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            pred.check_run({start_position, pixel_value, run_length, tile_end, store_full});
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Send one byte, opening a new burst after a random gap when due
    task automatic send_byte(input logic [DATA_W-1:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (in_stall);
        pred.take_byte(b);
    endtask

    task automatic send_noise();
        send_byte(DATA_W'($urandom_range(0, 255)));
    endtask

    // Drop valid and wait until every queued run has come out
    task automatic wait_idle();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (pred.runs_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        pred.set_reg(idx, val);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int unsigned cap, input int unsigned grp);
        wait_idle();
        write_reg(REG_CAPACITY, CFG_W'(cap));
        write_reg(REG_GROUP, CFG_W'(grp));
        settings_used++;
    endtask

    // One well-formed tile: runs up to the next tile boundary, then the
    // end-of-tile pixel and its skip bytes
    task automatic send_tile();
        int unsigned rem;
        int unsigned n;
        int unsigned kind;
        int unsigned top;
        while (pred.phase != PH_HEADER) send_noise();
        rem = 1023 - (pred.pos % 1024);
        while (rem > 0)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
            begin
                top = (rem < 127) ? rem : 127;
                n   = $urandom_range(1, top);
                send_byte(8'h80 | n[6:0]);
                send_noise();
                rem -= n;
            end
            else if (kind < 9)
            begin
                top = (kind == 8) ? 127 : 6;
                if (top > rem) top = rem;
                n = $urandom_range(1, top);
                send_byte(n[7:0]);
                repeat (n) send_noise();
                rem -= n;
            end
            else
            begin
                // Empty repeat run
                send_byte(8'h80);
                send_noise();
            end
        end
        send_byte(8'h00);
        send_noise();
        while (pred.phase == PH_SKIP) send_noise();
    endtask

    initial
    begin
        int unsigned ph;
        int unsigned cap;
        int unsigned lo;
        int unsigned first;
        int unsigned room;
        int unsigned n;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: store of one tile (capacity zero), no group skip
        configure(0, 0);
        send_byte(8'h81); send_byte(8'h00);
        send_byte(8'hFF); send_byte(8'hFF);
        send_byte(8'h80); send_byte(8'h5A);
        send_byte(8'h01); send_byte(8'hA5);
        send_byte(8'h03); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80);
        send_byte(8'h00); send_byte(8'h7F); send_byte(8'h00); send_byte(8'hFF);

        // Directed: smallest legal capacity, widest group, spare indexes
        configure(1, 511);
        write_reg(REG_SPARE_2, CFG_W'($urandom_range(0, 511)));
        write_reg(REG_SPARE_3, CFG_W'($urandom_range(0, 511)));
        send_byte(8'h02); send_byte(8'h55); send_byte(8'hAA);
        send_byte(8'h00); send_byte(8'hC3); send_byte(8'hFF); send_byte(8'h00);
        send_byte(8'h8A); send_byte(8'h3C);

        // Random phases: mostly well-formed tiles, some raw noise
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            lo = (pred.pos >> 10) + 40;
            if (ph == 0 || ph == 4)
                cap = 511;
            else if (ph == 1)
                cap = 256;
            else
                cap = $urandom_range(lo, 511);
            case (ph)
                0:       configure(cap, 1);
                1:       configure(cap, 2);
                2:       configure(cap, 0);
                3:       configure(cap, 3);
                default: configure(cap, 256);
            endcase
            first = pred.bytes_taken;
            while (pred.bytes_taken - first < PHASE_ITEMS &&
                   (pred.pos >> 10) + 4 < pred.cap_bytes() / TILE_BYTES_DEF)
            begin
                if ($urandom_range(0, 4) != 0)
                    send_tile();
                else
                    repeat ($urandom_range(1, 12)) send_noise();
            end
        end

        // Final phase: room for at most one tile, decode until the store fills
        configure((pred.pos >> 10) + 1, $urandom_range(1, 4));
        while (!pred.full)
        begin
            room = pred.cap_bytes() - pred.pos;
            if (pred.phase != PH_HEADER)
            begin
                send_noise();
            end
            else if (room > 127)
            begin
                n = $urandom_range(1, 127);
                send_byte(8'h80 | n[6:0]);
                send_noise();
            end
            else if ($urandom_range(0, 1) == 1)
            begin
                // Repeat run clipped at capacity
                send_byte(8'hFF);
                send_noise();
            end
            else
            begin
                // Literal run running past capacity
                send_byte(8'h7F);
                repeat (127) send_noise();
            end
        end
        // A full store ignores everything
        repeat (16) send_noise();

        // Drain and let the pipeline settle
        in_valid <= 1'b0;
        while (pred.runs_due.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Run covered %0d bytes and %0d runs: %0d end-of-tile pixels, %0d group skips.",
                 pred.bytes_taken, pred.runs_checked, pred.tile_ends, pred.group_hits);
        $display("Register settings used: %0d; store filled at position %0d.",
                 settings_used, pred.pos);
        if (pred.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: sim.f
hdl/trle_pkg.sv
hdl/trle_step.sv
hdl/trle_group.sv
hdl/tile_rle_stream_decoder.sv
dv/tb_tile_rle_stream_decoder.sv
